[src/mvt_pkg.sv]
// mvt_pkg: shared widths, types and register codes for motor_voltage_from_torque
// no dependencies; used by every module in src
package mvt_pkg;

  // data format
  localparam int VALUE_W = 24;
  localparam int FRAC_W  = 12;
  localparam int REG_W   = 16;
  localparam int LANES   = 3;

  // root path: |torque| * inverse_gain, then integer square root
  localparam int PROD_W = VALUE_W + REG_W;
  localparam int ROOT_W = (PROD_W + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;

  // bracket path: resistance + speed_gain * signed speed
  localparam int SW_W  = VALUE_W + 1;
  localparam int GSW_W = REG_W + 1 + SW_W;
  localparam int B_W   = GSW_W + 1;
  localparam int BF_W  = B_W - FRAC_W;

  // voltage path
  localparam int VP_W = ROOT_W + 1 + BF_W;
  localparam int V_W  = VP_W - FRAC_W;

  // edges from acceptance to a lane's registered voltage
  localparam int LANE_LAT = ROOT_W + 4;

  localparam logic [VALUE_W-1:0] V_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] V_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  localparam int IDX_W = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_INVERSE_GAIN,
    REG_SPEED_GAIN,
    REG_WINDING_RES
  } reg_index_t;

  localparam logic [REG_W-1:0] INVERSE_GAIN_RST = REG_W'(24779);
  localparam logic [REG_W-1:0] SPEED_GAIN_RST   = REG_W'(677);
  localparam logic [REG_W-1:0] WINDING_RES_RST  = REG_W'(11171);

  typedef struct packed {
    logic [REG_W-1:0] inverse_gain;
    logic [REG_W-1:0] speed_gain;
    logic [REG_W-1:0] winding_resistance;
  } cfg_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] voltage;
    logic                      clip;
  } lane_out_t;

endpackage

[src/motor_voltage_from_torque.sv]
// motor_voltage_from_torque: top level with config registers, word tracking and three lanes
// depends on mvt_pkg, mvt_lane, mvt_merge
//
// channel   direction  handshake            payload
// command   in         start, busy          torque_one..three, speed_one..three
// result    out        done (one cycle)     voltage_one..three, clipped
// config    in         cfg_write            cfg_index, cfg_data
//
// one word is taken every cycle while busy is low; each result follows its start through
// the lane stages and the merge register, the lane depth being set mostly by the square
// root pipeline, one root bit per stage.
// busy is high only for the cycle after reset; words in flight at reset are dropped.
// the result is held on the ports for one cycle with done; the receiver cannot stall.
module motor_voltage_from_torque (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [mvt_pkg::VALUE_W-1:0]  torque_one,
  input  logic signed [mvt_pkg::VALUE_W-1:0]  torque_two,
  input  logic signed [mvt_pkg::VALUE_W-1:0]  torque_three,
  input  logic signed [mvt_pkg::VALUE_W-1:0]  speed_one,
  input  logic signed [mvt_pkg::VALUE_W-1:0]  speed_two,
  input  logic signed [mvt_pkg::VALUE_W-1:0]  speed_three,
  output logic                                done,
  output logic signed [mvt_pkg::VALUE_W-1:0]  voltage_one,
  output logic signed [mvt_pkg::VALUE_W-1:0]  voltage_two,
  output logic signed [mvt_pkg::VALUE_W-1:0]  voltage_three,
  output logic                                clipped,
  input  logic                                cfg_write,
  input  logic [mvt_pkg::IDX_W-1:0]           cfg_index,
  input  logic [mvt_pkg::REG_W-1:0]           cfg_data
);

  localparam int LAT = mvt_pkg::LANE_LAT;

  mvt_pkg::cfg_t                       cfg;
  logic                                accept;
  logic [LAT-1:0]                      vld;
  logic signed [mvt_pkg::VALUE_W-1:0]  torque_v [mvt_pkg::LANES];
  logic signed [mvt_pkg::VALUE_W-1:0]  speed_v  [mvt_pkg::LANES];
  mvt_pkg::lane_out_t                  lane_res [mvt_pkg::LANES];

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inverse_gain       <= mvt_pkg::INVERSE_GAIN_RST;
      cfg.speed_gain         <= mvt_pkg::SPEED_GAIN_RST;
      cfg.winding_resistance <= mvt_pkg::WINDING_RES_RST;
    end else if (cfg_write) begin
      case (mvt_pkg::reg_index_t'(cfg_index))
        mvt_pkg::REG_INVERSE_GAIN: cfg.inverse_gain       <= cfg_data;
        mvt_pkg::REG_SPEED_GAIN:   cfg.speed_gain         <= cfg_data;
        mvt_pkg::REG_WINDING_RES:  cfg.winding_resistance <= cfg_data;
        default: ;
      endcase
    end
  end

  // one valid bit per lane stage, lanes run in lockstep
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], accept};
    end
  end

  assign torque_v[0] = torque_one;
  assign torque_v[1] = torque_two;
  assign torque_v[2] = torque_three;
  assign speed_v[0]  = speed_one;
  assign speed_v[1]  = speed_two;
  assign speed_v[2]  = speed_three;

  for (genvar i = 0; i < mvt_pkg::LANES; i++) begin : g_lane
    mvt_lane u_lane (
      .clk    (clk),
      .cfg    (cfg),
      .torque (torque_v[i]),
      .speed  (speed_v[i]),
      .result (lane_res[i])
    );
  end

  mvt_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .valid         (vld[LAT-1]),
    .lanes         (lane_res),
    .done          (done),
    .voltage_one   (voltage_one),
    .voltage_two   (voltage_two),
    .voltage_three (voltage_three),
    .clipped       (clipped)
  );

  a_word_returns: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(LAT + 1) done)
    else $error("accepted word did not produce a result");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT + 1))
    else $error("result without a matching accepted word");

  a_zero_torque: assert property (@(posedge clk) disable iff (rst)
    accept && (torque_one == '0) |-> ##(LAT + 1) (voltage_one == '0))
    else $error("zero torque gave a nonzero voltage");

  a_ready_after_reset: assert property (@(posedge clk)
    !rst && $past(!rst) |-> !busy)
    else $error("busy raised outside reset");

endmodule

[src/mvt_isqrt.sv]
// mvt_isqrt: pipelined integer square root, one root bit per stage
// depends on mvt_pkg
module mvt_isqrt (
  input  logic                        clk,
  input  logic [mvt_pkg::PROD_W-1:0]  radicand,
  output logic [mvt_pkg::ROOT_W-1:0]  root
);

  localparam int RW = mvt_pkg::ROOT_W;
  localparam int DW = mvt_pkg::RAD_W;
  localparam int MW = mvt_pkg::REM_W;

  logic [MW-1:0] rem_q  [RW-1];
  logic [DW-1:0] rad_q  [RW-1];
  logic [RW-1:0] root_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [MW-1:0] rem_in;
    logic [MW-1:0] rem_sh;
    logic [MW-1:0] trial;
    logic [MW-1:0] diff;
    logic [RW-1:0] root_in;
    logic [DW-1:0] rad_in;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = DW'(radicand);
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign rem_sh = {rem_in[RW-1:0], rad_in[DW-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign diff   = rem_sh - trial;
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      root_q[k] <= {root_in[RW-2:0], ge};
    end

    if (k < RW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_q[k] <= ge ? diff : rem_sh;
        rad_q[k] <= rad_in << 2;
      end
    end
  end

  assign root = root_q[RW-1];

endmodule

[src/mvt_lane.sv]
// mvt_lane: one motor's voltage pipeline (magnitude, products, root, scale, saturate)
// depends on mvt_pkg and mvt_isqrt
module mvt_lane (
  input  logic                                clk,
  input  mvt_pkg::cfg_t                       cfg,
  input  logic signed [mvt_pkg::VALUE_W-1:0]  torque,
  input  logic signed [mvt_pkg::VALUE_W-1:0]  speed,
  output mvt_pkg::lane_out_t                  result
);

  localparam int VW = mvt_pkg::VALUE_W;
  localparam int FB = mvt_pkg::FRAC_W;
  localparam int RW = mvt_pkg::ROOT_W;

  logic signed [mvt_pkg::SW_W-1:0]   speed_ext;
  logic                              neg1;
  logic        [VW-1:0]              mag1;
  logic signed [mvt_pkg::SW_W-1:0]   sw1;
  logic                              neg2;
  logic        [mvt_pkg::PROD_W-1:0] p2;
  logic signed [mvt_pkg::GSW_W-1:0]  gsw2;
  logic signed [mvt_pkg::B_W-1:0]    b3;
  logic signed [mvt_pkg::BF_W-1:0]   bf_q  [RW];
  logic                              neg_q [RW];
  logic        [RW-1:0]              root;
  logic signed [mvt_pkg::VP_W-1:0]   prod;
  logic                              neg_p;
  logic signed [mvt_pkg::VP_W-1:0]   sv;
  logic signed [mvt_pkg::V_W-1:0]    vs;
  logic        [mvt_pkg::V_W-VW:0]   upper;
  logic                              in_range;

  assign speed_ext = {speed[VW-1], speed};

  // resistance lifted to the product scale plus the speed term, floored below
  assign b3 = {gsw2[mvt_pkg::GSW_W-1], gsw2}
            + mvt_pkg::B_W'({cfg.winding_resistance, {FB{1'b0}}});

  mvt_isqrt u_isqrt (
    .clk      (clk),
    .radicand (p2),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    neg1 <= torque[VW-1];
    mag1 <= torque[VW-1] ? (~torque + 1'b1) : torque;
    sw1  <= torque[VW-1] ? -speed_ext : speed_ext;

    neg2 <= neg1;
    p2   <= mag1 * cfg.inverse_gain;
    gsw2 <= $signed({1'b0, cfg.speed_gain}) * sw1;

    bf_q[0]  <= b3[mvt_pkg::B_W-1:FB];
    neg_q[0] <= neg2;
    for (int k = 1; k < RW; k++) begin
      bf_q[k]  <= bf_q[k-1];
      neg_q[k] <= neg_q[k-1];
    end

    prod  <= $signed({1'b0, root}) * bf_q[RW-1];
    neg_p <= neg_q[RW-1];

    result.voltage <= in_range ? vs[VW-1:0]
                               : (vs[mvt_pkg::V_W-1] ? mvt_pkg::V_MIN : mvt_pkg::V_MAX);
    result.clip    <= !in_range;
  end

  // sign applied before the floor so negative results round down
  assign sv       = neg_p ? -prod : prod;
  assign vs       = sv[mvt_pkg::VP_W-1:FB];
  assign upper    = vs[mvt_pkg::V_W-1:VW-1];
  assign in_range = (&upper) | ~(|upper);

endmodule

[src/mvt_merge.sv]
// mvt_merge: output register stage, joins the lane voltages and their clip flags
// depends on mvt_pkg
module mvt_merge (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                valid,
  input  mvt_pkg::lane_out_t                  lanes [mvt_pkg::LANES],
  output logic                                done,
  output logic signed [mvt_pkg::VALUE_W-1:0]  voltage_one,
  output logic signed [mvt_pkg::VALUE_W-1:0]  voltage_two,
  output logic signed [mvt_pkg::VALUE_W-1:0]  voltage_three,
  output logic                                clipped
);

  logic any_clip;

  always_comb begin
    any_clip = 1'b0;
    for (int i = 0; i < mvt_pkg::LANES; i++) begin
      any_clip = any_clip | lanes[i].clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid;
    end
  end

  always_ff @(posedge clk) begin
    voltage_one   <= lanes[0].voltage;
    voltage_two   <= lanes[1].voltage;
    voltage_three <= lanes[2].voltage;
    clipped       <= any_clip;
  end

endmodule
